@@ hdl/mdfft_pkg.sv @@
// ----------------------------------------------------------------------------
// mdfft_pkg
// Shared constants, request codes and twiddle ROM builder for the
// multidimensional radix-2 FFT.
// ----------------------------------------------------------------------------
package mdfft_pkg;

  localparam int LOG2_MAX_POINTS   = 12;
  localparam int MAX_DIMS          = 3;
  localparam int DATA_WIDTH        = 32;
  localparam int TWIDDLE_FRAC_BITS = 16;
  localparam int TW_LOG            = (LOG2_MAX_POINTS < 2) ? 2 : LOG2_MAX_POINTS;
  localparam int TW_QUARTER        = 1 << (TW_LOG - 2);
  localparam int TW_W              = TWIDDLE_FRAC_BITS + 2;
  localparam int ROM_AW            = TW_LOG - 1;
  localparam logic [63:0] PI_Q30   = 64'd3373259426;

  // request codes
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_RUN   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // configuration register indexes
  localparam logic [2:0] CFG_DIM_COUNT = 3'd0;
  localparam logic [2:0] CFG_LEN0      = 3'd1;
  localparam logic [2:0] CFG_LEN1      = 3'd2;
  localparam logic [2:0] CFG_LEN2      = 3'd3;
  localparam logic [2:0] CFG_INVERSE   = 3'd4;

  typedef logic [TW_W-2:0] cos_rom_t [0:TW_QUARTER];

  // Quarter cosine wave: Taylor series in Q30, rounded to unsigned Q1.16
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t           rom;
    logic [63:0]        x;
    logic [63:0]        t;
    logic signed [63:0] sum;
    for (int k = 0; k <= TW_QUARTER; k++) begin
      x   = (64'(k) * PI_Q30 + (64'd1 << (TW_LOG - 2))) >> (TW_LOG - 1);
      t   = 64'd1 << 30;
      sum = $signed(t);
      for (int n = 1; n <= 28; n++) begin
        t = ((t * x) >> 30) / 64'(n);
        if ((n % 4) == 0) sum = sum + $signed(t);
        else if ((n % 4) == 2) sum = sum - $signed(t);
      end
      if (sum < 0) sum = 0;
      rom[k] = (TW_W-1)'((64'(sum) + (64'd1 << (29 - TWIDDLE_FRAC_BITS)))
                         >> (30 - TWIDDLE_FRAC_BITS));
    end
    return rom;
  endfunction

endpackage

@@ hdl/multidim_radix2_fft_top.sv @@
// ----------------------------------------------------------------------------
// multidim_radix2_fft_top
// In-place fixed-point radix-2 DIT FFT over up to three dimensions.
// ----------------------------------------------------------------------------
// Samples live in one 4096 x 64 single-port memory. A write item is stored
// while idle; a read item passes through S_RD to the output register. A run
// item first checks the dimension setup; on success each dimension gets a
// bit-reverse pass (swapping pairs through S_BR_RQ, S_BR_WP and S_BR_WQ) and
// then log2(len) butterfly passes over all N points, each butterfly going
// through S_BF_RQ, S_M0 to S_M5, S_WQ and S_WP, all bound by the single memory
// port and one shared 32x18 multiplier. No new item is taken until the
// current result has left the output register.
module multidim_radix2_fft_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [mdfft_pkg::LOG2_MAX_POINTS-1:0] in_point_index,
  input  logic signed [mdfft_pkg::DATA_WIDTH-1:0] in_sample_real,
  input  logic signed [mdfft_pkg::DATA_WIDTH-1:0] in_sample_imag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic signed [mdfft_pkg::DATA_WIDTH-1:0] out_result_real,
  output logic signed [mdfft_pkg::DATA_WIDTH-1:0] out_result_imag,
  output logic        out_status,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_wdata
);
  import mdfft_pkg::*;

  localparam int AW = LOG2_MAX_POINTS;
  localparam int DW = DATA_WIDTH;
  localparam int PW = DW + TW_W;       // product width
  localparam int TWD = PW + 1 - TWIDDLE_FRAC_BITS;   // rounded twiddled width
  localparam cos_rom_t COS_ROM = build_cos_rom();

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_RD    = 17'h00002,
    S_OUT   = 17'h00004,
    S_BR    = 17'h00008,
    S_BR_RQ = 17'h00010,
    S_BR_WP = 17'h00020,
    S_BR_WQ = 17'h00040,
    S_BF    = 17'h00080,
    S_BF_RQ = 17'h00100,
    S_M0    = 17'h00200,
    S_M1    = 17'h00400,
    S_M2    = 17'h00800,
    S_M3    = 17'h01000,
    S_M4    = 17'h02000,
    S_M5    = 17'h04000,
    S_WQ    = 17'h08000,
    S_WP    = 17'h10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [1:0] dim_count_r;
  logic [3:0] len_r [0:3];
  logic       inverse_r;

  // sequencing
  logic [1:0]    dim_r;
  logic [3:0]    shift_r, bits_r, s_r, total_r;
  logic [AW-1:0] p_r;

  // datapath registers
  logic [2*DW-1:0]      rd_r, a_r, x0_r, x1_r, x0_early_r;
  logic [TW_W-2:0]      rc_r, rs_r;
  logic                 negc_r;
  logic signed [TW_W-1:0] c_r, sn_r;
  logic signed [PW-1:0] prod_r;
  logic signed [PW:0]   acc_r;
  logic signed [TWD-1:0] tr_r, ti_r;
  logic                 out_kind_r, out_status_r;
  logic [DW-1:0]        out_real_r, out_imag_r;

  logic [2*DW-1:0] mem [0:(1<<AW)-1];
  logic            mem_we;
  logic [AW-1:0]   mem_addr;
  logic [2*DW-1:0] mem_wd;

  // address arithmetic for the current index
  logic [AW-1:0] mask, tot_mask, d, rev, r, q, half, k;
  logic          p_last, s_last, d_upper;
  logic [ROM_AW-1:0] ca, sa;
  logic          negc;
  logic [4:0]    run_total;
  logic          run_err;

  always_comb begin
    mask     = AW'((13'd1 << bits_r) - 13'd1);
    tot_mask = AW'((13'd1 << total_r) - 13'd1);
    d        = (p_r >> shift_r) & mask;
    for (int i = 0; i < AW; i++) rev[i] = d[AW-1-i];
    r        = rev >> (4'(AW) - bits_r);
    q        = (r > d) ? p_r + ((r - d) << shift_r) : p_r;
    half     = AW'(1) << s_r;
    d_upper  = |(d & half);
    k        = AW'(({1'b0, d & (half - AW'(1))}) << (4'(TW_LOG - 1) - s_r));
    if (k <= AW'(TW_QUARTER)) begin
      ca   = ROM_AW'(k);
      sa   = ROM_AW'(AW'(TW_QUARTER) - k);
      negc = 1'b0;
    end else begin
      ca   = ROM_AW'(AW'(2*TW_QUARTER) - k);
      sa   = ROM_AW'(k - AW'(TW_QUARTER));
      negc = 1'b1;
    end
    if (state_r == S_BF || state_r == S_BF_RQ || state_r == S_M0 ||
        state_r == S_WQ || state_r == S_WP)
      q = p_r + (half << shift_r);
    p_last = (p_r == tot_mask);
    s_last = (s_r == bits_r - 4'd1);
  end

  // run request check
  always_comb begin
    run_total = 5'd0;
    run_err   = (dim_count_r == 2'd0) || (32'(dim_count_r) > MAX_DIMS);
    for (int i = 0; i < MAX_DIMS; i++) begin
      if (2'(i) < dim_count_r) begin
        if (len_r[i] == 4'd0) run_err = 1'b1;
        run_total = run_total + 5'(len_r[i]);
      end
    end
    if (32'(run_total) > LOG2_MAX_POINTS) run_err = 1'b1;
  end

  // butterfly arithmetic
  function automatic logic [DW-1:0] sat(input logic signed [TWD:0] v);
    logic signed [TWD:0] hi, lo;
    hi = (TWD+1)'({1'b0, {(DW-1){1'b1}}});
    lo = -hi - 1;
    if (v > hi) return DW'(hi);
    if (v < lo) return DW'(lo);
    return DW'(v);
  endfunction

  logic signed [DW-1:0]   mul_a;
  logic signed [TW_W-1:0] mul_b;
  logic signed [PW:0]     rsum;
  logic signed [TWD:0]    x0re, x0im;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_M1:    begin mul_a = x1_r[2*DW-1:DW]; mul_b = c_r;  end
      S_M2:    begin mul_a = x1_r[DW-1:0];    mul_b = sn_r; end
      S_M3:    begin mul_a = x1_r[2*DW-1:DW]; mul_b = sn_r; end
      S_M4:    begin mul_a = x1_r[DW-1:0];    mul_b = c_r;  end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    if (state_r == S_M3) rsum = acc_r - prod_r;
    else rsum = acc_r + prod_r;
    rsum = rsum + (PW+1)'(1 <<< (TWIDDLE_FRAC_BITS - 1));
    x0re = (TWD+1)'($signed(x0_r[2*DW-1:DW]));
    x0im = (TWD+1)'($signed(x0_r[DW-1:0]));
  end

  // memory port and next state
  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_addr  = p_r;
    mem_wd    = rd_r;
    case (state_r)
      S_IDLE: begin
        mem_addr = in_point_index;
        mem_wd   = {in_sample_real, in_sample_imag};
        if (in_valid) begin
          case (in_req_type)
            REQ_WRITE: mem_we = 1'b1;
            REQ_RUN:   state_nxt = run_err ? S_OUT : S_BR;
            REQ_READ:  state_nxt = S_RD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD:    state_nxt = S_OUT;
      S_OUT:   if (!out_stall) state_nxt = S_IDLE;
      S_BR: begin
        if (r > d) state_nxt = S_BR_RQ;
        else if (p_last) state_nxt = S_BF;
      end
      S_BR_RQ: begin
        mem_addr  = q;
        state_nxt = S_BR_WP;
      end
      S_BR_WP: begin
        mem_we    = 1'b1;
        mem_wd    = rd_r;
        state_nxt = S_BR_WQ;
      end
      S_BR_WQ: begin
        mem_addr  = q;
        mem_we    = 1'b1;
        mem_wd    = a_r;
        state_nxt = p_last ? S_BF : S_BR;
      end
      S_BF: begin
        if (!d_upper) state_nxt = S_BF_RQ;
        else if (p_last && s_last)
          state_nxt = (dim_r == dim_count_r - 2'd1) ? S_OUT : S_BR;
      end
      S_BF_RQ: begin
        mem_addr  = q;
        state_nxt = S_M0;
      end
      S_M0:    state_nxt = S_M1;
      S_M1:    state_nxt = S_M2;
      S_M2:    state_nxt = S_M3;
      S_M3:    state_nxt = S_M4;
      S_M4:    state_nxt = S_M5;
      S_M5:    state_nxt = S_WQ;
      S_WQ: begin
        mem_addr  = q;
        mem_we    = 1'b1;
        mem_wd    = {sat(x0re - (TWD+1)'(tr_r)), sat(x0im - (TWD+1)'(ti_r))};
        state_nxt = S_WP;
      end
      S_WP: begin
        mem_we = 1'b1;
        mem_wd = {sat(x0re + (TWD+1)'(tr_r)), sat(x0im + (TWD+1)'(ti_r))};
        if (p_last && s_last)
          state_nxt = (dim_r == dim_count_r - 2'd1) ? S_OUT : S_BR;
        else
          state_nxt = S_BF;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sample memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    rd_r <= mem[mem_addr];
  end

  // twiddle lookup and datapath
  always_ff @(posedge clk) begin
    rc_r   <= COS_ROM[ca];
    rs_r   <= COS_ROM[sa];
    negc_r <= negc;
    prod_r <= mul_a * mul_b;
    case (state_r)
      S_BR_RQ: a_r <= rd_r;
      S_BF_RQ: begin
        c_r  <= negc_r ? -$signed({1'b0, rc_r}) : $signed({1'b0, rc_r});
        sn_r <= inverse_r ? -$signed({1'b0, rs_r}) : $signed({1'b0, rs_r});
      end
      S_M0: begin
        x0_r <= x0_early_r;
        x1_r <= rd_r;
      end
      S_M2:    acc_r <= (PW+1)'(prod_r);
      S_M3:    tr_r  <= TWD'(rsum >>> TWIDDLE_FRAC_BITS);
      S_M4:    acc_r <= (PW+1)'(prod_r);
      S_M5:    ti_r  <= TWD'(rsum >>> TWIDDLE_FRAC_BITS);
      default: a_r   <= a_r;
    endcase
  end

  // x0 is read in S_BF and x1 in S_BF_RQ; keep x0 until x1 arrives
  always_ff @(posedge clk) begin
    if (state_r == S_BF_RQ) x0_early_r <= rd_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      dim_count_r  <= 2'd1;
      len_r[0]     <= 4'd3;
      len_r[1]     <= 4'd0;
      len_r[2]     <= 4'd0;
      len_r[3]     <= 4'd0;
      inverse_r    <= 1'b0;
      dim_r        <= '0;
      shift_r      <= '0;
      bits_r       <= '0;
      s_r          <= '0;
      total_r      <= '0;
      p_r          <= '0;
      out_kind_r   <= 1'b0;
      out_status_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DIM_COUNT: dim_count_r <= cfg_wdata[1:0];
          CFG_LEN0:      len_r[0]    <= cfg_wdata;
          CFG_LEN1:      len_r[1]    <= cfg_wdata;
          CFG_LEN2:      len_r[2]    <= cfg_wdata;
          CFG_INVERSE:   inverse_r   <= cfg_wdata[0];
          default:       inverse_r   <= inverse_r;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          dim_r   <= '0;
          shift_r <= '0;
          bits_r  <= len_r[0];
          total_r <= run_total[3:0];
          s_r     <= '0;
          p_r     <= '0;
          if (in_valid && in_req_type == REQ_RUN) begin
            out_kind_r   <= 1'b0;
            out_status_r <= run_err;
          end
        end
        S_RD: begin
          out_kind_r   <= 1'b1;
          out_status_r <= 1'b0;
        end
        S_BR: begin
          if (!(r > d)) begin
            p_r <= p_last ? '0 : p_r + AW'(1);
            if (p_last) s_r <= '0;
          end
        end
        S_BR_WQ: begin
          p_r <= p_last ? '0 : p_r + AW'(1);
          if (p_last) s_r <= '0;
        end
        S_BF, S_WP: begin
          if (state_r == S_WP || d_upper) begin
            if (!p_last) begin
              p_r <= p_r + AW'(1);
            end else if (!s_last) begin
              p_r <= '0;
              s_r <= s_r + 4'd1;
            end else begin
              p_r     <= '0;
              s_r     <= '0;
              dim_r   <= dim_r + 2'd1;
              shift_r <= shift_r + bits_r;
              bits_r  <= len_r[dim_r + 2'd1];
              out_kind_r   <= 1'b0;
              out_status_r <= 1'b0;
            end
          end
        end
        default: p_r <= p_r;
      endcase
    end
  end

  // read data into the output register; cleared while idle
  always_ff @(posedge clk) begin
    if (state_r == S_RD) begin
      out_real_r <= rd_r[2*DW-1:DW];
      out_imag_r <= rd_r[DW-1:0];
    end else if (state_r == S_IDLE) begin
      out_real_r <= '0;
      out_imag_r <= '0;
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_result_kind = out_kind_r;
  assign out_result_real = out_real_r;
  assign out_result_imag = out_imag_r;
  assign out_status      = out_status_r;

endmodule
